[rtl/overflow_checked_integer_alu_top_assert.svh]
// Assertion macros for the checked integer ALU.
`ifndef OVERFLOW_CHECKED_INTEGER_ALU_TOP_ASSERT_SVH
`define OVERFLOW_CHECKED_INTEGER_ALU_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define OCIA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ocia assertion failed");
`define OCIA_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("ocia forbidden condition seen");
`else
`define OCIA_ASSERT(lbl, prop)
`define OCIA_ASSERT_NEVER(lbl, expr)
`endif
`endif

[rtl/ocia_pkg.sv]
`timescale 1ns / 1ps
package ocia_pkg;

  localparam int unsigned DataWidthDefault = 32;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

endpackage

[rtl/overflow_checked_integer_alu_top.sv]
`timescale 1ns / 1ps
// Signed integer ALU with overflow and divide-error flag. Every word runs
// through DATA_WIDTH + 3 register stages (input, operand prep, one stage per
// operand bit for the shift-add multiply and restoring divide, output) for
// every opcode, and a new word can be taken every cycle unless the pipe is
// full and stalled. Each stage holds its word while the next one is full
// and stalled; empty stages ahead still fill, so the input keeps flowing
// until the whole pipe is full. Divide by zero and minimum / -1 give 0.
`include "overflow_checked_integer_alu_top_assert.svh"
module overflow_checked_integer_alu_top #(
  parameter int unsigned DATA_WIDTH = ocia_pkg::DataWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   op_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] result_value_o,
  output logic                         error_flag_o
);
  import ocia_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned NS = W + 2;

  typedef struct packed {
    op_e            op;
    logic [W-1:0]   a;
    logic [W-1:0]   b;
    logic           neg;
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [2*W-1:0] acc;
    logic [W-1:0]   res;
    logic           err;
  } stage_t;

  localparam logic [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MaxVal = {1'b0, {(W-1){1'b1}}};

  stage_t       st_q [NS];
  stage_t       st_d [NS];
  logic [NS-1:0] vld_q;
  logic [NS:0]   rdy;

  logic         out_valid_q;
  logic [W-1:0] result_value_q, result_value_d;
  logic         error_q, error_d;

  // stall chain: a stage takes a word when it is empty or its word moves on
  assign rdy[NS] = !out_valid_q || out_ready_i;
  for (genvar k = 0; k < NS; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end
  assign in_ready_o = rdy[0];

  // capture the incoming word
  always_comb begin
    st_d[0]    = '0;
    st_d[0].op = op_e'(op_i);
    st_d[0].a  = operand_a_i;
    st_d[0].b  = operand_b_i;
  end

  // prep: magnitudes, result sign, add and subtract
  always_comb begin
    logic [W-1:0] sum;
    logic [W-1:0] diff;
    sum  = st_q[0].a + st_q[0].b;
    diff = st_q[0].a - st_q[0].b;
    st_d[1]     = st_q[0];
    st_d[1].neg = st_q[0].a[W-1] ^ st_q[0].b[W-1];
    st_d[1].ma  = st_q[0].a[W-1] ? (~st_q[0].a + 1'b1) : st_q[0].a;
    st_d[1].mb  = st_q[0].b[W-1] ? (~st_q[0].b + 1'b1) : st_q[0].b;
    st_d[1].acc = '0;
    if (st_q[0].op == OP_SUB) begin
      st_d[1].res = diff;
      st_d[1].err = (st_q[0].a[W-1] != st_q[0].b[W-1]) && (diff[W-1] != st_q[0].a[W-1]);
    end else begin
      st_d[1].res = sum;
      st_d[1].err = (st_q[0].a[W-1] == st_q[0].b[W-1]) && (sum[W-1] != st_q[0].a[W-1]);
    end
  end

  // one operand bit per stage: shift-add multiply or restoring divide
  for (genvar i = 0; i < W; i++) begin : g_iter
    always_comb begin
      logic [W:0]     rem_s;
      logic [W:0]     rem_n;
      logic           ge;
      logic [2*W-1:0] addend;
      rem_s  = {st_q[i+1].acc[W-1:0], st_q[i+1].ma[W-1]};
      ge     = rem_s >= {1'b0, st_q[i+1].mb};
      rem_n  = ge ? (rem_s - {1'b0, st_q[i+1].mb}) : rem_s;
      addend = st_q[i+1].mb[i] ? ({{W{1'b0}}, st_q[i+1].ma} << i) : '0;
      st_d[i+2] = st_q[i+1];
      if (st_q[i+1].op == OP_DIV) begin
        st_d[i+2].acc = {{(W-1){1'b0}}, rem_n};
        st_d[i+2].ma  = {st_q[i+1].ma[W-2:0], ge};
      end else begin
        st_d[i+2].acc = st_q[i+1].acc + addend;
      end
    end
  end

  // advance each stage when it is free to take a word
  for (genvar k = 0; k < NS; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        vld_q[k] <= (k == 0) ? in_valid_i : vld_q[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (rdy[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // finish: pass add/sub result, apply sign, check product range and divide errors
  always_comb begin
    stage_t       f;
    logic [W-1:0] lo;
    logic [W-1:0] limit;
    f     = st_q[NS-1];
    lo    = f.acc[W-1:0];
    limit = f.neg ? MinVal : MaxVal;
    case (f.op)
      OP_ADD, OP_SUB: begin
        result_value_d = f.res;
        error_d        = f.err;
      end
      OP_MUL: begin
        result_value_d = f.neg ? (~lo + 1'b1) : lo;
        error_d        = (|f.acc[2*W-1:W]) || (lo > limit);
      end
      OP_DIV: begin
        if ((f.b == '0) || ((f.a == MinVal) && (f.b == '1))) begin
          result_value_d = '0;
          error_d        = 1'b1;
        end else begin
          result_value_d = f.neg ? (~f.ma + 1'b1) : f.ma;
          error_d        = 1'b0;
        end
      end
      default: begin
        result_value_d = '0;
        error_d        = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[NS]) begin
      out_valid_q <= vld_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS]) begin
      result_value_q <= result_value_d;
      error_q        <= error_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = result_value_q;
  assign error_flag_o   = error_q;

  `OCIA_ASSERT(a_ready_when_front_empty, !vld_q[0] |-> in_ready_o)
  `OCIA_ASSERT(a_div_zero_gives_zero, vld_q[NS-1] && rdy[NS] && (st_q[NS-1].op == OP_DIV) && (st_q[NS-1].b == '0) |=> out_valid_q && error_q && (result_value_q == '0))
  `OCIA_ASSERT(a_last_stage_holds, vld_q[NS-1] && !rdy[NS] |=> vld_q[NS-1] && $stable(st_q[NS-1].acc))
  `OCIA_ASSERT_NEVER(a_in_ready_while_full_stalled, (&vld_q) && out_valid_q && !out_ready_i && in_ready_o)

endmodule
